FILE: hw/rtl/itc_pkg.sv
// shared types, constants and helpers for the integer to text converter
package itc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_CHARS_DEF   = 11;

  // conversion kinds
  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_OCT  = 2'd2;
  localparam logic [1:0] CMD_HEX  = 2'd3;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // one digit value to its lowercase ascii code
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] code;
    if (d < 4'd10) begin
      code = CHAR_ZERO + {4'h0, d};
    end else begin
      code = CHAR_LC_A + {4'h0, d} - 8'd10;
    end
    return code;
  endfunction

endpackage

FILE: hw/rtl/integer_to_text_converter_unit.sv
// integer to ascii text converter: signed/unsigned decimal, octal, lowercase hex
// decimal: a minus sign first when negative, then shift-add-3 over all VALUE_WIDTH bits, then zero
//   skip and character output
// octal/hex: zero skip and character output
// one request at a time, and output stalls hold the sign and character output;
//   rst_n is synchronous active low, back to idle, no out_valid
module integer_to_text_converter_unit #(
  parameter int VALUE_WIDTH = itc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = itc_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output itc_pkg::out_req_t out_data
);

  // octal needs the most digits, so the digit register is sized for it
  localparam int DIG_N = (VALUE_WIDTH + 2) / 3;
  localparam int BCD_W = DIG_N * 4;
  localparam int OCT_W = DIG_N * 3;
  localparam int IT_W  = $clog2(VALUE_WIDTH);
  localparam int REM_W = $clog2(DIG_N + 1);
  localparam int CNT_W = $clog2(MAX_CHARS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CHARS - 1);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(DIG_N);
  localparam logic [IT_W-1:0]  IT_LAST  = IT_W'(VALUE_WIDTH - 1);

  // control state
  itc_pkg::state_t state_r, state_nxt;
  logic [IT_W-1:0]  iter_r, iter_nxt;    // shift-add-3 steps left
  logic [REM_W-1:0] rem_r, rem_nxt;      // digits left in the digit register
  logic [CNT_W-1:0] cnt_r, cnt_nxt;      // characters already sent
  logic             out_valid_r, out_valid_nxt;

  // datapath
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;   // digits, most significant at the top
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;   // binary bits still to shift in
  itc_pkg::out_req_t      out_data_r, out_data_nxt;

  // input decode
  logic [VALUE_WIDTH-1:0] v_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   is_neg;
  logic [OCT_W-1:0]       v_oct;
  logic [BCD_W-1:0]       oct_dig;
  logic [BCD_W-1:0]       hex_dig;
  logic [BCD_W-1:0]       bcd_adj;
  logic [3:0]             top_dig;
  logic                   can_load;
  logic                   emit_last;

  assign v_in    = VALUE_WIDTH'(in_data.value);
  assign is_neg  = (in_data.cmd == itc_pkg::CMD_SDEC) && v_in[VALUE_WIDTH-1];
  assign mag     = is_neg ? (~v_in + 1'b1) : v_in;
  assign v_oct   = OCT_W'(v_in);
  assign hex_dig = BCD_W'(v_in);
  assign top_dig = bcd_r[BCD_W-1 -: 4];

  // octal digits widened to one nibble each
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      oct_dig[i*4 +: 4] = {1'b0, v_oct[i*3 +: 3]};
    end
  end

  // shift-add-3 unit: every bcd digit of five or more gets three added
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                     : bcd_r[i*4 +: 4];
    end
  end

  // output register is free when empty or being drained this cycle
  assign can_load  = !out_valid_r || out_ready;
  assign emit_last = (rem_r == REM_W'(1)) || (cnt_r == CNT_LAST);

  assign in_ready  = (state_r == itc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    bcd_nxt       = bcd_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      itc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          rem_nxt = REM_FULL;
          if (in_data.cmd inside {itc_pkg::CMD_SDEC, itc_pkg::CMD_UDEC}) begin
            bin_nxt   = mag;
            bcd_nxt   = '0;
            iter_nxt  = IT_LAST;
            state_nxt = is_neg ? itc_pkg::ST_SIGN : itc_pkg::ST_CONV;
          end else begin
            bcd_nxt   = (in_data.cmd == itc_pkg::CMD_OCT) ? oct_dig : hex_dig;
            state_nxt = itc_pkg::ST_SKIP;
          end
        end
      end

      // minus sign goes out while the magnitude waits
      itc_pkg::ST_SIGN: begin
        if (can_load) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = itc_pkg::CHAR_MINUS;
          out_data_nxt.last      = (cnt_r == CNT_LAST);
          cnt_nxt                = cnt_r + 1'b1;
          state_nxt = (cnt_r == CNT_LAST) ? itc_pkg::ST_IDLE : itc_pkg::ST_CONV;
        end
      end

      // one binary bit into the bcd digits per cycle
      itc_pkg::ST_CONV: begin
        bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt  = {bin_r[VALUE_WIDTH-2:0], 1'b0};
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          state_nxt = itc_pkg::ST_SKIP;
        end
      end

      // drop leading zero digits, always keep the final one
      itc_pkg::ST_SKIP: begin
        if ((top_dig == 4'h0) && (rem_r != REM_W'(1))) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = itc_pkg::ST_EMIT;
        end
      end

      itc_pkg::ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = itc_pkg::digit_char(top_dig);
          out_data_nxt.last      = emit_last;
          bcd_nxt                = {bcd_r[BCD_W-5:0], 4'h0};
          rem_nxt                = rem_r - 1'b1;
          cnt_nxt                = cnt_r + 1'b1;
          if (emit_last) begin
            state_nxt = itc_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = itc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itc_pkg::ST_IDLE;
      iter_r      <= '0;
      rem_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bcd_r      <= bcd_nxt;
    bin_r      <= bin_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // a new request is never taken back to back with the previous one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while still busy");

  // the digit walk never runs out of digits
  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itc_pkg::ST_SKIP || state_r == itc_pkg::ST_EMIT) |-> (rem_r != '0))
    else $error("digit register walked past its end");

  // conversion hands over to the zero skip after the final bit
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itc_pkg::ST_CONV && iter_r == '0) |=> (state_r == itc_pkg::ST_SKIP))
    else $error("conversion did not end after the last bit");

  // only a minus sign or a lowercase digit ever leaves the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.char_code == itc_pkg::CHAR_MINUS) ||
                   (out_data.char_code >= itc_pkg::CHAR_ZERO &&
                    out_data.char_code <= itc_pkg::CHAR_NINE) ||
                   (out_data.char_code >= itc_pkg::CHAR_LC_A &&
                    out_data.char_code <= itc_pkg::CHAR_LC_F)))
    else $error("character outside the digit set");
`endif

endmodule
